>>> hw/rtl/ncc_pkg.sv
// Shared types and constants for the nearest centroid classifier.
// Used by ncc_cell and nearest_centroid_classifier; depends on nothing.
`default_nettype none

package ncc_pkg;

    localparam int DEF_MAX_CLUSTERS = 16;
    localparam int DEF_FEATURES     = 64;

    localparam int VAL_W = 16;      // feature value width
    localparam int DIF_W = 17;      // signed difference of two values
    localparam int SQ_W  = 34;      // square of a difference
    localparam int ACC_W = 38;      // distance accumulator
    localparam int IDX_W = 6;       // centroid index, up to 64 centroids
    localparam int CNT_W = 7;       // active centroid count, up to 64

    localparam logic [ACC_W-1:0] ACC_MAX = '1;

    // Operation carried in tuser
    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_ELEMENT = 1'b1
    } op_t;

    // Running minimum handed from cell to cell during the compare sweep
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic [ACC_W-1:0] dist_sq;
    } tok_t;

    // Per-cell strobes from the top level
    typedef struct packed {
        logic wr_en;    // write the centroid feature
        logic rd_en;    // read the centroid feature for an element item
        logic acc_en;   // add the squared difference
    } cell_ctl_t;

endpackage : ncc_pkg

`default_nettype wire

>>> hw/rtl/ncc_cell.sv
// One centroid cell: feature memory, squared-difference pipe, accumulator
// and one step of the minimum search chain. Depends on ncc_pkg.
`default_nettype none

module ncc_cell #(
    parameter int FEATURES = ncc_pkg::DEF_FEATURES,
    parameter int CELL_ID  = 0,
    parameter int FEAT_AW  = (FEATURES > 1) ? $clog2(FEATURES) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ncc_pkg::cell_ctl_t            ctl,
    input  wire logic [FEAT_AW-1:0]            addr,
    input  wire logic [ncc_pkg::VAL_W-1:0]     wdata,
    input  wire logic [ncc_pkg::VAL_W-1:0]     elem_value,  // stage 1 element value
    input  wire logic [ncc_pkg::CNT_W-1:0]     act_cnt,
    input  wire ncc_pkg::tok_t                 tok_in,
    output ncc_pkg::tok_t                      tok_out
);

    logic [ncc_pkg::VAL_W-1:0] mem [FEATURES];
    logic [ncc_pkg::VAL_W-1:0] rd_data_reg;

    logic signed [ncc_pkg::DIF_W-1:0] diff_reg;
    logic signed [ncc_pkg::DIF_W-1:0] diff_next;
    logic [ncc_pkg::SQ_W-1:0]         sq_reg;
    logic signed [2*ncc_pkg::DIF_W-1:0] prod;
    logic [ncc_pkg::ACC_W-1:0]        acc_reg;
    logic [ncc_pkg::ACC_W-1:0]        acc_next;
    logic [ncc_pkg::ACC_W:0]          sum;
    ncc_pkg::tok_t                    tok_reg;
    ncc_pkg::tok_t                    tok_next;
    logic                             active;
    logic                             take;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_comb
    begin
        diff_next = ncc_pkg::DIF_W'($signed({elem_value[ncc_pkg::VAL_W-1], elem_value})
                  - $signed({rd_data_reg[ncc_pkg::VAL_W-1], rd_data_reg}));
        prod      = diff_reg * diff_reg;
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        sq_reg   <= ncc_pkg::SQ_W'(prod);
    end

    // Saturating accumulate; clear once the search token has passed
    always_comb
    begin
        sum      = {1'b0, acc_reg} + (ncc_pkg::ACC_W + 1)'(sq_reg);
        acc_next = acc_reg;
        if (tok_in.valid)
        begin
            acc_next = '0;
        end
        else if (ctl.acc_en)
        begin
            acc_next = sum[ncc_pkg::ACC_W] ? ncc_pkg::ACC_MAX : sum[ncc_pkg::ACC_W-1:0];
        end
    end

    // Strict less-than keeps the lower index on ties
    always_comb
    begin
        active   = ncc_pkg::CNT_W'(CELL_ID) < act_cnt;
        take     = tok_in.valid && active && ((CELL_ID == 0) || (acc_reg < tok_in.dist_sq));
        tok_next = tok_in;
        if (take)
        begin
            tok_next.idx     = ncc_pkg::IDX_W'(CELL_ID);
            tok_next.dist_sq = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            tok_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule : ncc_cell

`default_nettype wire

>>> hw/rtl/nearest_centroid_classifier.sv
// Top level of the nearest centroid classifier: stream handshakes, control
// pipeline and the row of ncc_cell instances. Depends on ncc_pkg, ncc_cell.
//
//  channel  | signals                          | carries
//  ---------+----------------------------------+--------------------------------
//  input    | s_tvalid s_tready s_tdata        | load or element feature item
//           | s_tuser s_tlast                  |
//  output   | m_tvalid m_tready m_tdata        | nearest centroid and distance
//  config   | cfg_we cfg_wdata                 | active_clusters register
//
// Load items and element features are taken one per cycle while input is
// open. An element item with tlast closes input and passes a 3-stage
// squared-difference pipe, then a minimum token walks the cell chain; m_tvalid
// rises when the token leaves the last cell, and input reopens then. The sweep
// also waits for the output register to drain. Reset clears the accumulators
// and control; centroid memories are not cleared.
`default_nettype none

module nearest_centroid_classifier #(
    parameter int MAX_CLUSTERS = ncc_pkg::DEF_MAX_CLUSTERS,
    parameter int FEATURES     = ncc_pkg::DEF_FEATURES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // cluster_index[3:0] feature_index[9:4] value[25:10]
    input  wire logic        s_tuser,   // operation
    input  wire logic        s_tlast,   // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // best_cluster[3:0] min_distance_sq[41:4]
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_wdata
);

    localparam int FEAT_AW = (FEATURES > 1) ? $clog2(FEATURES) : 1;

    logic [3:0]                 in_cluster;
    logic [5:0]                 in_feature;
    logic [ncc_pkg::VAL_W-1:0]  in_value;
    logic                       accept;
    logic                       feat_ok;
    logic                       clus_ok;
    logic                       is_elem;
    logic [FEAT_AW-1:0]         addr;

    logic [4:0]                 act_cfg_reg;
    logic [ncc_pkg::CNT_W-1:0]  act_cnt;

    logic                       s1_acc_reg, s2_acc_reg, s3_acc_reg;
    logic                       s1_last_reg, s2_last_reg, s3_last_reg;
    logic [ncc_pkg::VAL_W-1:0]  s1_value_reg;
    logic                       busy_reg, busy_next;
    logic                       pend_reg, pend_next;
    logic                       start;

    logic                       m_valid_reg, m_valid_next;
    logic [3:0]                 m_idx_reg;
    logic [ncc_pkg::ACC_W-1:0]  m_dist_reg;

    ncc_pkg::tok_t              tok [MAX_CLUSTERS+1];
    ncc_pkg::cell_ctl_t         ctl [MAX_CLUSTERS];

    assign in_cluster = s_tdata[3:0];
    assign in_feature = s_tdata[9:4];
    assign in_value   = s_tdata[25:10];
    assign s_tready   = !busy_reg;
    assign accept     = s_tvalid && s_tready;
    assign feat_ok    = 32'(in_feature) < FEATURES;
    assign clus_ok    = 32'(in_cluster) < MAX_CLUSTERS;
    assign is_elem    = (s_tuser != ncc_pkg::OP_LOAD);
    assign addr       = FEAT_AW'(in_feature);

    // Zero counts as one, anything above the cell count as the cell count
    always_comb
    begin
        if (act_cfg_reg == 5'd0)
        begin
            act_cnt = ncc_pkg::CNT_W'(1);
        end
        else if (32'(act_cfg_reg) > MAX_CLUSTERS)
        begin
            act_cnt = ncc_pkg::CNT_W'(MAX_CLUSTERS);
        end
        else
        begin
            act_cnt = ncc_pkg::CNT_W'(act_cfg_reg);
        end
    end

    always_comb
    begin
        start        = pend_reg && !m_valid_reg;
        pend_next    = pend_reg;
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (accept && is_elem && s_tlast)
        begin
            busy_next = 1'b1;
        end
        if (s3_last_reg)
        begin
            pend_next = 1'b1;
        end
        if (start)
        begin
            pend_next = 1'b0;
        end
        // Final token leaves the chain: load the result and reopen input
        if (tok[MAX_CLUSTERS].valid)
        begin
            m_valid_next = 1'b1;
            busy_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_cfg_reg <= 5'd16;
            s1_acc_reg  <= 1'b0;
            s2_acc_reg  <= 1'b0;
            s3_acc_reg  <= 1'b0;
            s1_last_reg <= 1'b0;
            s2_last_reg <= 1'b0;
            s3_last_reg <= 1'b0;
            busy_reg    <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                act_cfg_reg <= cfg_wdata;
            end
            s1_acc_reg  <= accept && is_elem && feat_ok;
            s2_acc_reg  <= s1_acc_reg;
            s3_acc_reg  <= s2_acc_reg;
            s1_last_reg <= accept && is_elem && s_tlast;
            s2_last_reg <= s1_last_reg;
            s3_last_reg <= s2_last_reg;
            busy_reg    <= busy_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_value_reg <= in_value;
        if (tok[MAX_CLUSTERS].valid)
        begin
            m_idx_reg  <= tok[MAX_CLUSTERS].idx[3:0];
            m_dist_reg <= tok[MAX_CLUSTERS].dist_sq;
        end
    end

    // Start token; cell 0 always takes it
    always_comb
    begin
        tok[0].valid   = start;
        tok[0].idx     = '0;
        tok[0].dist_sq = ncc_pkg::ACC_MAX;
    end

    for (genvar k = 0; k < MAX_CLUSTERS; k++)
    begin : g_cell
        always_comb
        begin
            ctl[k].wr_en  = accept && !is_elem && clus_ok && feat_ok
                         && (32'(in_cluster) == k);
            ctl[k].rd_en  = accept && is_elem && feat_ok;
            ctl[k].acc_en = s3_acc_reg;
        end

        ncc_cell #(
            .FEATURES (FEATURES),
            .CELL_ID  (k),
            .FEAT_AW  (FEAT_AW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl[k]),
            .addr       (addr),
            .wdata      (in_value),
            .elem_value (s1_value_reg),
            .act_cnt    (act_cnt),
            .tok_in     (tok[k]),
            .tok_out    (tok[k+1])
        );
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_dist_reg, m_idx_reg};

endmodule : nearest_centroid_classifier

`default_nettype wire
